[sv/psu_pkg.sv]
// Shared types and constants for the PNG scanline unfilter.
package psu_pkg;

    localparam int C_LINE_AW = 14;                          // line store address bits
    localparam int C_LINE_DEPTH = 1 << C_LINE_AW;           // bytes held per scanline
    localparam int C_HIST_DEPTH = 8;                        // deepest left neighbor
    localparam int C_HIST_IW = 3;                           // history index bits

    localparam logic [14:0] C_MAX_LINE_BYTES = 15'd16384;
    localparam logic [3:0]  C_MAX_PIXEL_BYTES = 4'd8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PIXEL_BYTES = 2'd0;
    localparam logic [1:0] CFG_LINE_BYTES  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_ROWS  = 2'd2;

    // Filter type codes; anything else reconstructs as None.
    localparam logic [7:0] FILTER_NONE  = 8'd0;
    localparam logic [7:0] FILTER_SUB   = 8'd1;
    localparam logic [7:0] FILTER_UP    = 8'd2;
    localparam logic [7:0] FILTER_AVG   = 8'd3;
    localparam logic [7:0] FILTER_PAETH = 8'd4;

    typedef logic [7:0] t_byte;
    typedef logic [C_LINE_AW-1:0] t_col;

    // Per data byte information from the position tracker to the compute stage.
    typedef struct packed {
        t_byte filter;
        t_col  col;
        logic  a_ok;      // left neighbor lies inside the row
        logic  b_ok;      // a row above exists
        logic  row_end;
        logic  image_end;
    } t_item;

endpackage

[sv/psu_line_store.sv]
// Previous-scanline byte store with one write port and one registered read port.
module psu_line_store (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  psu_pkg::t_col        i_waddr,
    input  psu_pkg::t_byte       i_wdata,
    input  logic                 i_re,
    input  psu_pkg::t_col        i_raddr,
    output psu_pkg::t_byte       o_rdata
);

    psu_pkg::t_byte mem [psu_pkg::C_LINE_DEPTH];
    psu_pkg::t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/psu_position.sv]
// Row and column tracker: splits the stream into filter bytes and data bytes.
module psu_position (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  psu_pkg::t_byte    i_byte,
    input  logic              i_start,
    input  logic [3:0]        i_pixel_bytes,
    input  logic [14:0]       i_line_bytes,
    input  logic [15:0]       i_image_rows,
    output logic              o_is_data,
    output psu_pkg::t_item    o_item
);

    psu_pkg::t_col  r_column, n_column;
    logic [15:0]    r_row, n_row;
    psu_pkg::t_byte r_filter, n_filter;
    logic           r_await, n_await;

    logic        row_end;
    logic        image_end;
    logic [16:0] row_plus;

    assign o_is_data = !(i_start || r_await);

    assign row_end   = ({1'b0, r_column} + 15'd1) >= i_line_bytes;
    assign row_plus  = {1'b0, r_row} + 17'd1;
    assign image_end = row_end && (row_plus >= {1'b0, i_image_rows});

    always_comb begin
        o_item.filter    = r_filter;
        o_item.col       = r_column;
        o_item.a_ok      = {10'd0, i_pixel_bytes} <= r_column;
        o_item.b_ok      = r_row != 16'd0;
        o_item.row_end   = row_end;
        o_item.image_end = image_end;
    end

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        n_filter = r_filter;
        n_await  = r_await;
        if (i_accept) begin
            if (!o_is_data) begin
                // Filter type byte; a start mark also abandons the current position.
                n_filter = i_byte;
                n_await  = 1'b0;
                n_column = '0;
                if (i_start) begin
                    n_row = '0;
                end
            end else if (row_end) begin
                n_column = '0;
                n_await  = 1'b1;
                n_row    = image_end ? 16'd0 : row_plus[15:0];
            end else begin
                n_column = r_column + psu_pkg::t_col'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
            r_filter <= psu_pkg::FILTER_NONE;
            r_await  <= 1'b1;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
            r_filter <= n_filter;
            r_await  <= n_await;
        end
    end

endmodule

[sv/psu_recon.sv]
// Filter reconstruction of one byte from its left, up and up-left neighbors.
module psu_recon (
    input  psu_pkg::t_byte i_filter,
    input  psu_pkg::t_byte i_x,
    input  psu_pkg::t_byte i_a,
    input  psu_pkg::t_byte i_b,
    input  psu_pkg::t_byte i_c,
    output psu_pkg::t_byte o_r
);

    // Distances to p = a + b - c reduce to |b - c|, |a - c| and |a + b - 2c|.
    function automatic psu_pkg::t_byte paeth(input psu_pkg::t_byte a,
                                             input psu_pkg::t_byte b,
                                             input psu_pkg::t_byte c);
        logic signed [10:0] pa;
        logic signed [10:0] pb;
        logic signed [10:0] pc;
        psu_pkg::t_byte     res;
        pa = $signed({3'd0, b}) - $signed({3'd0, c});
        pb = $signed({3'd0, a}) - $signed({3'd0, c});
        pc = pa + pb;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

    logic [8:0] avg_sum;

    assign avg_sum = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        unique case (i_filter)
            psu_pkg::FILTER_SUB:   o_r = i_x + i_a;
            psu_pkg::FILTER_UP:    o_r = i_x + i_b;
            psu_pkg::FILTER_AVG:   o_r = i_x + avg_sum[8:1];
            psu_pkg::FILTER_PAETH: o_r = i_x + paeth(i_a, i_b, i_c);
            default:               o_r = i_x;
        endcase
    end

endmodule

[sv/png_scanline_unfilter.sv]
// Top level of the PNG scanline unfilter: handshake, compute stage and output register.
//
// The slave stream carries the inflated PNG image data, one byte per transaction:
// tdata is the byte, tuser marks the first byte of a new image. The first byte of
// every scanline is the filter type and produces no output transaction; each later
// byte produces exactly one reconstructed byte on the master stream, with tlast on
// the last byte of a scanline and tuser on the last byte of the image.
// The configuration port sets bytes per pixel, bytes per scanline and the row count;
// the user must write it between images while the block is idle; it is not enforced.
// A data byte accepted on the slave side passes the compute stage registers and then
// the output register. Throughput: one byte per cycle while the master side does not
// stall. The loop from the left-neighbor history through the adder back into the
// history registers and the single registered line store read port set that rate.
// Reset sets the registers to 1, clears the position and expects a filter byte.
// The line store has no clearing pass; its read is ignored when no row above exists.
// When the master side stalls, the output register holds its transaction and one
// more byte waits in the compute stage; only then does tready fall.
module png_scanline_unfilter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,      // [7:0] in_byte
    input  logic        s_axis_tuser,      // [0] start_image
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,      // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,      // [0] image_end
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers and their effective values.
    logic [3:0]  r_pixel_bytes;
    logic [14:0] r_line_bytes;
    logic [15:0] r_image_rows;
    logic [3:0]  pixel_bytes;
    logic [14:0] line_bytes;
    logic [15:0] image_rows;
    logic [3:0]  pixel_m1;
    logic [psu_pkg::C_HIST_IW-1:0] hist_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes <= 4'd1;
            r_line_bytes  <= 15'd1;
            r_image_rows  <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psu_pkg::CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[3:0];
                psu_pkg::CFG_LINE_BYTES:  r_line_bytes  <= i_cfg_data[14:0];
                psu_pkg::CFG_IMAGE_ROWS:  r_image_rows  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_pixel_bytes == 4'd0) begin
            pixel_bytes = 4'd1;
        end else if (r_pixel_bytes > psu_pkg::C_MAX_PIXEL_BYTES) begin
            pixel_bytes = psu_pkg::C_MAX_PIXEL_BYTES;
        end else begin
            pixel_bytes = r_pixel_bytes;
        end
        priority if (r_line_bytes == 15'd0) begin
            line_bytes = 15'd1;
        end else if (r_line_bytes > psu_pkg::C_MAX_LINE_BYTES) begin
            line_bytes = psu_pkg::C_MAX_LINE_BYTES;
        end else begin
            line_bytes = r_line_bytes;
        end
        image_rows = (r_image_rows == 16'd0) ? 16'd1 : r_image_rows;
    end

    assign pixel_m1 = pixel_bytes - 4'd1;
    assign hist_idx = pixel_m1[psu_pkg::C_HIST_IW-1:0];

    // Handshake and pipeline control.
    logic in_accept;
    logic is_data;
    logic s1_adv;
    logic out_load;
    logic r_s1_valid;
    logic r_out_valid;
    psu_pkg::t_item item;

    assign out_load      = !r_out_valid || m_axis_tready;
    assign s1_adv        = r_s1_valid && out_load;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    psu_position u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_byte        (s_axis_tdata),
        .i_start       (s_axis_tuser),
        .i_pixel_bytes (pixel_bytes),
        .i_line_bytes  (line_bytes),
        .i_image_rows  (image_rows),
        .o_is_data     (is_data),
        .o_item        (item)
    );

    // Compute stage registers; the line store read lands alongside them.
    psu_pkg::t_item r_s1_item;
    psu_pkg::t_byte r_s1_x;
    psu_pkg::t_byte up_rdata;
    psu_pkg::t_byte recon;
    psu_pkg::t_byte nb_a;
    psu_pkg::t_byte nb_b;
    psu_pkg::t_byte nb_c;
    psu_pkg::t_byte r_left_hist [psu_pkg::C_HIST_DEPTH];
    psu_pkg::t_byte r_upleft_hist [psu_pkg::C_HIST_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= is_data;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_data) begin
            r_s1_item <= item;
            r_s1_x    <= s_axis_tdata;
        end
    end

    psu_line_store u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_item.col),
        .i_wdata (recon),
        .i_re    (in_accept && is_data),
        .i_raddr (item.col),
        .o_rdata (up_rdata)
    );

    assign nb_a = r_s1_item.a_ok ? r_left_hist[hist_idx] : 8'd0;
    assign nb_b = r_s1_item.b_ok ? up_rdata : 8'd0;
    assign nb_c = (r_s1_item.a_ok && r_s1_item.b_ok) ? r_upleft_hist[hist_idx] : 8'd0;

    psu_recon u_recon (
        .i_filter (r_s1_item.filter),
        .i_x      (r_s1_x),
        .i_a      (nb_a),
        .i_b      (nb_b),
        .i_c      (nb_c),
        .o_r      (recon)
    );

    // Newest first: entry k holds the byte k + 1 data bytes back.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_left_hist[0]   <= recon;
            r_upleft_hist[0] <= nb_b;
            for (int k = 1; k < psu_pkg::C_HIST_DEPTH; k++) begin
                r_left_hist[k]   <= r_left_hist[k-1];
                r_upleft_hist[k] <= r_upleft_hist[k-1];
            end
        end
    end

    // Output register.
    logic [7:0] r_out_byte;
    logic       r_out_row_end;
    logic       r_out_image_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_byte      <= recon;
            r_out_row_end   <= r_s1_item.row_end;
            r_out_image_end <= r_s1_item.image_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_row_end;
    assign m_axis_tuser  = r_out_image_end;

    // The image end only ever falls on a scanline end.
    a_image_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("image end without row end");

    // Input back-pressure only when both stages hold a byte and the sink stalls.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a full pipeline");

    // A byte leaving the compute stage is presented on the next cycle.
    a_advance_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> m_axis_tvalid)
        else $error("advanced byte not presented");

endmodule
